@@ rtl/core/dhtsr_pkg.sv @@
// Shared types, register indexes, phase codes and reset values for the DHT11 sensor responder.
`default_nettype none
package dhtsr_pkg;

	// Frame layout: humidity, zero, temperature, zero, checksum
	localparam int FRAME_BITS = 40;
	localparam int CNT_W      = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Item kinds
	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_SAMPLE  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_LOW       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH      = 3'd5;

	// Configuration reset values in microseconds
	localparam logic [7:0] RST_RESPONSE_LOW  = 8'd80;
	localparam logic [7:0] RST_RESPONSE_HIGH = 8'd80;
	localparam logic [7:0] RST_ERROR_HIGH    = 8'd90;
	localparam logic [7:0] RST_BIT_LOW       = 8'd20;
	localparam logic [7:0] RST_ZERO_HIGH     = 8'd23;
	localparam logic [7:0] RST_ONE_HIGH      = 8'd75;

	// Phase codes
	localparam logic [2:0] PH_START     = 3'd0;
	localparam logic [2:0] PH_RESP_LOW  = 3'd1;
	localparam logic [2:0] PH_RESP_HIGH = 3'd2;
	localparam logic [2:0] PH_BIT_LOW   = 3'd3;
	localparam logic [2:0] PH_BIT_HIGH  = 3'd4;

	typedef struct packed {
		logic        kind;
		logic [15:0] elapsed_us;
		logic [7:0]  humidity;
		logic [7:0]  temperature;
		logic        reading_valid;
	} in_item_t;

	typedef struct packed {
		logic             line_level;
		logic [CNT_W-1:0] bits_sent;
	} out_item_t;

	typedef struct packed {
		logic [7:0] response_low_us;
		logic [7:0] response_high_us;
		logic [7:0] error_high_us;
		logic [7:0] bit_low_us;
		logic [7:0] zero_high_us;
		logic [7:0] one_high_us;
	} cfg_regs_t;

endpackage
`default_nettype wire

@@ rtl/core/dhtsr_cfg.sv @@
// Configuration register file for the DHT11 sensor responder timing values.
`default_nettype none
module dhtsr_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [dhtsr_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [dhtsr_pkg::CFG_DATA_W-1:0]   wr_data,
	output dhtsr_pkg::cfg_regs_t                    regs
);

	dhtsr_pkg::cfg_regs_t regs_q;

	// Write one register per transfer; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.response_low_us  <= dhtsr_pkg::RST_RESPONSE_LOW;
			regs_q.response_high_us <= dhtsr_pkg::RST_RESPONSE_HIGH;
			regs_q.error_high_us    <= dhtsr_pkg::RST_ERROR_HIGH;
			regs_q.bit_low_us       <= dhtsr_pkg::RST_BIT_LOW;
			regs_q.zero_high_us     <= dhtsr_pkg::RST_ZERO_HIGH;
			regs_q.one_high_us      <= dhtsr_pkg::RST_ONE_HIGH;
		end else if (wr_en) begin
			case (wr_index)
				dhtsr_pkg::CFG_RESPONSE_LOW:  regs_q.response_low_us  <= wr_data;
				dhtsr_pkg::CFG_RESPONSE_HIGH: regs_q.response_high_us <= wr_data;
				dhtsr_pkg::CFG_ERROR_HIGH:    regs_q.error_high_us    <= wr_data;
				dhtsr_pkg::CFG_BIT_LOW:       regs_q.bit_low_us       <= wr_data;
				dhtsr_pkg::CFG_ZERO_HIGH:     regs_q.zero_high_us     <= wr_data;
				dhtsr_pkg::CFG_ONE_HIGH:      regs_q.one_high_us      <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule
`default_nettype wire

@@ rtl/core/dhtsr_core.sv @@
// Phase state, bit counter, frame latch and line level decision for one item per cycle while step is high.
`default_nettype none
module dhtsr_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire dhtsr_pkg::in_item_t   item,
	input  wire dhtsr_pkg::cfg_regs_t  regs,
	output dhtsr_pkg::out_item_t       result
);

	logic [2:0]                       phase_q, phase_d;
	logic [dhtsr_pkg::CNT_W-1:0]      bit_count_q, bit_count_d;
	logic [dhtsr_pkg::FRAME_BITS-1:0] frame_q, frame_d;
	logic                             level;
	logic                             frame_done;
	logic [dhtsr_pkg::CNT_W-1:0]      bit_pos;
	logic [7:0]                       high_limit;
	logic [7:0]                       checksum;

	assign frame_done = bit_count_q >= dhtsr_pkg::CNT_W'(dhtsr_pkg::FRAME_BITS);
	// Most significant bit goes first
	assign bit_pos    = dhtsr_pkg::CNT_W'(dhtsr_pkg::FRAME_BITS - 1) - bit_count_q;
	assign high_limit = frame_q[bit_pos] ? regs.one_high_us : regs.zero_high_us;
	assign checksum   = item.humidity + item.temperature;

	// Decide the line level and next state for the current item; a restart item returns to the start phase
	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		frame_d     = frame_q;
		level       = 1'b0;
		if (item.kind == dhtsr_pkg::KIND_RESTART) begin
			phase_d     = dhtsr_pkg::PH_START;
			bit_count_d = '0;
		end else begin
			case (phase_q)
				dhtsr_pkg::PH_START: begin
					phase_d = dhtsr_pkg::PH_RESP_LOW;
				end
				dhtsr_pkg::PH_RESP_LOW: begin
					if (item.elapsed_us >= {8'd0, regs.response_low_us}) begin
						level   = 1'b1;
						phase_d = dhtsr_pkg::PH_RESP_HIGH;
					end
				end
				dhtsr_pkg::PH_RESP_HIGH: begin
					frame_d = {item.humidity, 8'd0, item.temperature, 8'd0, checksum};
					if (item.elapsed_us < {8'd0, regs.response_high_us}) begin
						level = 1'b1;
					end else if (item.reading_valid ||
							item.elapsed_us >= {8'd0, regs.error_high_us}) begin
						phase_d = dhtsr_pkg::PH_BIT_LOW;
					end else begin
						level = 1'b1;
					end
				end
				dhtsr_pkg::PH_BIT_LOW: begin
					if (frame_done) begin
						level = 1'b1;
					end else if (item.elapsed_us >= {8'd0, regs.bit_low_us}) begin
						level   = 1'b1;
						phase_d = dhtsr_pkg::PH_BIT_HIGH;
					end
				end
				dhtsr_pkg::PH_BIT_HIGH: begin
					if (frame_done) begin
						level   = 1'b1;
						phase_d = dhtsr_pkg::PH_BIT_LOW;
					end else if (item.elapsed_us < {8'd0, high_limit}) begin
						level = 1'b1;
					end else begin
						bit_count_d = bit_count_q + 1'b1;
						phase_d     = dhtsr_pkg::PH_BIT_LOW;
					end
				end
				default: ;
			endcase
		end
	end

	// Advance state once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dhtsr_pkg::PH_START;
			bit_count_q <= '0;
			frame_q     <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			frame_q     <= frame_d;
		end
	end

	assign result.line_level = level;
	assign result.bits_sent  = bit_count_d;

endmodule
`default_nettype wire

@@ rtl/core/dht11_sensor_responder_top.sv @@
// A sample item goes from the input register to the result register. Throughput: one item per
// cycle when results are not stalled; the state update is one compare and select per cycle.
// A restart item updates the state and produces no result.
// Reset: arst_n clears the phase, bit count, frame and pipeline valids asynchronously
// and loads the timing registers with their default microsecond values.
`default_nettype none
module dht11_sensor_responder_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire dhtsr_pkg::in_item_t               in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output dhtsr_pkg::out_item_t                   out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [dhtsr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dhtsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                 s1_valid_s1;
	dhtsr_pkg::in_item_t  item_s1;
	logic                 out_valid_q;
	dhtsr_pkg::out_item_t out_q;
	logic                 step;
	logic                 is_sample;
	dhtsr_pkg::cfg_regs_t regs;
	dhtsr_pkg::out_item_t result;

	assign cfg_ready = 1'b1;

	dhtsr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs)
	);

	// Process the held item when it needs no output slot or the slot frees up
	assign is_sample = item_s1.kind == dhtsr_pkg::KIND_SAMPLE;
	assign step      = s1_valid_s1 && (!is_sample || !out_valid_q || out_ready);
	assign in_ready  = !s1_valid_s1 || step;

	dhtsr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.regs   (regs),
		.result (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Result register: load on a processed sample, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && is_sample) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_sample) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_bits_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.bits_sent <= dhtsr_pkg::CNT_W'(dhtsr_pkg::FRAME_BITS))
		else $error("bits_sent beyond frame length");

	a_restart_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !is_sample && !out_valid_q) |=> !out_valid_q)
		else $error("restart item produced a result");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_s1 && is_sample && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

@@ test/dht11_sensor_responder_top_tb.sv @@
// Testbench for the DHT11 sensor responder: drives host exchanges and checks every line sample.
`timescale 1ns / 1ps

// Tracks the sensor's phase, bit count and frame; holds the line levels still owed by the block
class dht_line_tracker;
	logic [7:0]                       resp_low, resp_high, err_high, bit_low, zero_high, one_high;
	logic [2:0]                       phase;
	logic [dhtsr_pkg::CNT_W-1:0]      bit_count;
	logic [dhtsr_pkg::FRAME_BITS-1:0] frame;
	dhtsr_pkg::out_item_t             expected_levels[$];
	int                               errors, samples, restarts, frames_done, reg_writes;

	function new();
		resp_low    = dhtsr_pkg::RST_RESPONSE_LOW;
		resp_high   = dhtsr_pkg::RST_RESPONSE_HIGH;
		err_high    = dhtsr_pkg::RST_ERROR_HIGH;
		bit_low     = dhtsr_pkg::RST_BIT_LOW;
		zero_high   = dhtsr_pkg::RST_ZERO_HIGH;
		one_high    = dhtsr_pkg::RST_ONE_HIGH;
		phase       = dhtsr_pkg::PH_START;
		bit_count   = '0;
		frame       = '0;
		errors      = 0;
		samples     = 0;
		restarts    = 0;
		frames_done = 0;
		reg_writes  = 0;
	endfunction

	function void write_reg(logic [dhtsr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
		reg_writes++;
		case (idx)
			dhtsr_pkg::CFG_RESPONSE_LOW:  resp_low  = val;
			dhtsr_pkg::CFG_RESPONSE_HIGH: resp_high = val;
			dhtsr_pkg::CFG_ERROR_HIGH:    err_high  = val;
			dhtsr_pkg::CFG_BIT_LOW:       bit_low   = val;
			dhtsr_pkg::CFG_ZERO_HIGH:     zero_high = val;
			dhtsr_pkg::CFG_ONE_HIGH:      one_high  = val;
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_levels.size();
	endfunction

	// Threshold that ends the current phase; steers the host timer
	function int phase_limit();
		int lim;
		lim = 0;
		case (phase)
			dhtsr_pkg::PH_RESP_LOW:  lim = resp_low;
			dhtsr_pkg::PH_RESP_HIGH: lim = (err_high > resp_high) ? err_high : resp_high;
			dhtsr_pkg::PH_BIT_LOW:   lim = bit_low;
			dhtsr_pkg::PH_BIT_HIGH: begin
				if (bit_count < dhtsr_pkg::FRAME_BITS)
					lim = frame[dhtsr_pkg::FRAME_BITS - 1 - bit_count] ? one_high : zero_high;
			end
			default: lim = 0;
		endcase
		return lim;
	endfunction

	// Advance the sensor on one accepted transfer and queue the level that a sample owes
	function void note_input(dhtsr_pkg::in_item_t it);
		logic                 lvl;
		logic [7:0]           sum;
		int                   lim;
		dhtsr_pkg::out_item_t owed;
		if (it.kind == dhtsr_pkg::KIND_RESTART) begin
			phase     = dhtsr_pkg::PH_START;
			bit_count = '0;
			restarts++;
			return;
		end
		samples++;
		lvl = 1'b0;
		case (phase)
			dhtsr_pkg::PH_START: begin
				phase = dhtsr_pkg::PH_RESP_LOW;
			end
			dhtsr_pkg::PH_RESP_LOW: begin
				if (it.elapsed_us >= resp_low) begin
					lvl   = 1'b1;
					phase = dhtsr_pkg::PH_RESP_HIGH;
				end
			end
			dhtsr_pkg::PH_RESP_HIGH: begin
				// relatch the frame on every sample of the high response
				sum   = it.humidity + it.temperature;
				frame = {it.humidity, 8'h00, it.temperature, 8'h00, sum};
				if (it.elapsed_us < resp_high) begin
					lvl = 1'b1;
				end else if (it.reading_valid || it.elapsed_us >= err_high) begin
					phase = dhtsr_pkg::PH_BIT_LOW;
				end else begin
					lvl = 1'b1;
				end
			end
			dhtsr_pkg::PH_BIT_LOW: begin
				if (bit_count >= dhtsr_pkg::FRAME_BITS) begin
					lvl = 1'b1;
				end else if (it.elapsed_us >= bit_low) begin
					lvl   = 1'b1;
					phase = dhtsr_pkg::PH_BIT_HIGH;
				end
			end
			dhtsr_pkg::PH_BIT_HIGH: begin
				if (bit_count >= dhtsr_pkg::FRAME_BITS) begin
					lvl   = 1'b1;
					phase = dhtsr_pkg::PH_BIT_LOW;
				end else begin
					lim = frame[dhtsr_pkg::FRAME_BITS - 1 - bit_count] ? one_high : zero_high;
					if (it.elapsed_us < lim) begin
						lvl = 1'b1;
					end else begin
						bit_count++;
						phase = dhtsr_pkg::PH_BIT_LOW;
						if (bit_count == dhtsr_pkg::FRAME_BITS)
							frames_done++;
					end
				end
			end
			default: lvl = 1'b0;
		endcase
		owed.line_level = lvl;
		owed.bits_sent  = bit_count;
		expected_levels.push_back(owed);
	endfunction

	function void flag(string msg);
		errors++;
		$display("%s", msg);
	endfunction

	// Compare one output transfer with the oldest owed level
	function void check_result(dhtsr_pkg::out_item_t got);
		dhtsr_pkg::out_item_t want;
		if (expected_levels.size() == 0) begin
			flag($sformatf("%0t: result with nothing owed, line_level=%0b bits_sent=%0d",
				$time, got.line_level, got.bits_sent));
			return;
		end
		want = expected_levels.pop_front();
		if (got.line_level !== want.line_level)
			flag($sformatf("%0t: line_level expected %0b, actual %0b",
				$time, want.line_level, got.line_level));
		if (got.bits_sent !== want.bits_sent)
			flag($sformatf("%0t: bits_sent expected %0d, actual %0d",
				$time, want.bits_sent, got.bits_sent));
	endfunction
endclass

module dht11_sensor_responder_top_tb;
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	dhtsr_pkg::in_item_t              in_data = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	dhtsr_pkg::out_item_t             out_data;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [dhtsr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dhtsr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int                               src_idle_pct = 14;
	int                               sink_idle_pct = 71;
	int                               settings_run = 0;
	dht_line_tracker                  tracker = new();

	dht11_sensor_responder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always #4 clk = ~clk;

	// Stall the result channel at random
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= sink_idle_pct);
	end

	// Observe every transfer on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				tracker.note_input(in_data);
			if (out_valid && out_ready)
				tracker.check_result(out_data);
		end
	end

	function automatic dhtsr_pkg::in_item_t make_item(logic kind, logic [15:0] t,
			logic [7:0] hum, logic [7:0] temp, logic valid);
		dhtsr_pkg::in_item_t it;
		it.kind          = kind;
		it.elapsed_us    = t;
		it.humidity      = hum;
		it.temperature   = temp;
		it.reading_valid = valid;
		return it;
	endfunction

	// Offer one item after a random gap; return at the falling edge after its transfer
	task automatic send_item(input dhtsr_pkg::in_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed level has come back
	task automatic settle();
		in_valid = 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// Hold the write channel up until the register transfer; caller drops valid
	task automatic write_reg(input logic [dhtsr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_regs(input logic [7:0] rl, rh, eh, bl, zh, oh);
		settle();
		write_reg(dhtsr_pkg::CFG_RESPONSE_LOW, rl);
		write_reg(dhtsr_pkg::CFG_RESPONSE_HIGH, rh);
		write_reg(dhtsr_pkg::CFG_ERROR_HIGH, eh);
		write_reg(dhtsr_pkg::CFG_BIT_LOW, bl);
		write_reg(dhtsr_pkg::CFG_ZERO_HIGH, zh);
		write_reg(dhtsr_pkg::CFG_ONE_HIGH, oh);
		cfg_valid = 1'b0;
		settings_run++;
	endtask

	// Run host exchanges: restart, then mostly samples whose timer restarts on every phase change
	task automatic run_exchanges(input int budget);
		dhtsr_pkg::in_item_t it;
		int                  sent, lim, tval, tail;
		logic [2:0]          host_phase;
		sent = 0;
		while (sent < budget) begin
			send_item(make_item(dhtsr_pkg::KIND_RESTART, 16'($urandom), 8'($urandom),
				8'($urandom), 1'($urandom)));
			sent++;
			host_phase = tracker.phase;
			tval = 0;
			tail = $urandom_range(1, 4);
			while (sent < budget && tail > 0) begin
				// abandon the frame now and then
				if ($urandom_range(99) < 3)
					break;
				if ($urandom_range(99) < 6) begin
					it = make_item(1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom));
				end else begin
					if (tracker.phase != host_phase) begin
						host_phase = tracker.phase;
						tval = 0;
					end
					lim = tracker.phase_limit();
					if ($urandom_range(1) == 1)
						tval += lim + $urandom_range(0, 3);
					else
						tval += $urandom_range(0, lim / 2 + 1);
					if (tval > 65535)
						tval = 65535;
					it = make_item(dhtsr_pkg::KIND_SAMPLE, 16'(tval), 8'($urandom),
						8'($urandom), $urandom_range(99) < 60);
				end
				send_item(it);
				sent++;
				if (tracker.bit_count >= dhtsr_pkg::FRAME_BITS)
					tail--;
			end
		end
	endtask

	initial begin
		int         seg;
		logic [7:0] rh;
		logic       rst_k;
		logic       smp_k;
		rst_k = dhtsr_pkg::KIND_RESTART;
		smp_k = dhtsr_pkg::KIND_SAMPLE;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default timing: full walk through start, response and the first bits
		send_item(make_item(rst_k, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
		send_item(make_item(smp_k, 16'd0, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd0, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd79, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd80, 8'h00, 8'h00, 1'b1));
		// invalid reading stretches the high response
		send_item(make_item(smp_k, 16'd0, 8'hFF, 8'hFF, 1'b0));
		send_item(make_item(smp_k, 16'd85, 8'hFF, 8'hFF, 1'b0));
		send_item(make_item(smp_k, 16'd90, 8'hFF, 8'hFF, 1'b0));
		send_item(make_item(smp_k, 16'd19, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd20, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd74, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd75, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'hFFFF, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'hFFFF, 8'h00, 8'h00, 1'b1));
		// restart in the middle of a frame, then an all-zero frame
		send_item(make_item(rst_k, 16'd0, 8'h00, 8'h00, 1'b0));
		send_item(make_item(smp_k, 16'hFFFF, 8'hFF, 8'hFF, 1'b0));
		send_item(make_item(smp_k, 16'hFFFF, 8'hFF, 8'hFF, 1'b0));
		send_item(make_item(smp_k, 16'd100, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd20, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd22, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd23, 8'h00, 8'h00, 1'b1));
		// stretch limit below the normal high: invalid reading ends at the normal length
		settle();
		write_reg(dhtsr_pkg::CFG_ERROR_HIGH, 8'd10);
		cfg_valid = 1'b0;
		send_item(make_item(rst_k, 16'd0, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd0, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd80, 8'h00, 8'h00, 1'b1));
		send_item(make_item(smp_k, 16'd80, 8'h5A, 8'hA5, 1'b0));

		// Random exchanges under three idling patterns and nine timing settings
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					src_idle_pct  = 14;
					sink_idle_pct = 71;
				end
				1: begin
					src_idle_pct  = 71;
					sink_idle_pct = 14;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 3; k++) begin
				seg = mode * 3 + k;
				case (seg)
					0: write_regs(dhtsr_pkg::RST_RESPONSE_LOW, dhtsr_pkg::RST_RESPONSE_HIGH,
						dhtsr_pkg::RST_ERROR_HIGH, dhtsr_pkg::RST_BIT_LOW,
						dhtsr_pkg::RST_ZERO_HIGH, dhtsr_pkg::RST_ONE_HIGH);
					1: write_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
					2: write_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
					4: begin
						rh = 8'($urandom_range(40, 255));
						write_regs(8'($urandom_range(31)), rh, 8'($urandom_range(rh)),
							8'($urandom_range(31)), 8'($urandom_range(31)),
							8'($urandom_range(31)));
					end
					5: write_regs(8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom), 8'($urandom));
					7: write_regs($urandom_range(1) ? 8'hFF : 8'h00,
						$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
						$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
						$urandom_range(1) ? 8'hFF : 8'h00);
					default: write_regs(8'($urandom_range(31)), 8'($urandom_range(31)),
						8'($urandom_range(31)), 8'($urandom_range(31)),
						8'($urandom_range(31)), 8'($urandom_range(31)));
				endcase
				run_exchanges(145);
			end
		end

		// Drain and let any stray result show up
		settle();
		repeat (8) @(posedge clk);
		$display("Ran %0d line samples and %0d restarts over %0d timing settings (%0d writes).",
			tracker.samples, tracker.restarts, settings_run, tracker.reg_writes);
		$display("%0d frames reached the last bit; %0d failures seen.",
			tracker.frames_done, tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: end a hung run
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ dht11_sensor_responder_top.f @@
rtl/core/dhtsr_pkg.sv
rtl/core/dhtsr_cfg.sv
rtl/core/dhtsr_core.sv
rtl/core/dht11_sensor_responder_top.sv
test/dht11_sensor_responder_top_tb.sv
